/* design/lpdi_pkg.sv */
// Shared types and constants for the LED panel driver init sequencer.
`timescale 1ns / 1ps

package lpdi_pkg;

  localparam int MaxRow   = 4096;
  localparam int MinRow   = 16;
  localparam int ColWidth = 13;
  localparam int WordBits = 16;

  typedef logic [ColWidth-1:0] col_t;
  typedef logic [WordBits-1:0] word_t;
  typedef logic [1:0]          kind_t;
  typedef logic [1:0]          cfg_idx_t;

  localparam kind_t KindPlain = 2'd0;
  localparam kind_t KindFm    = 2'd1;
  localparam kind_t KindDp    = 2'd2;
  localparam kind_t KindMbi   = 2'd3;

  localparam cfg_idx_t CfgKind   = 2'd0;
  localparam cfg_idx_t CfgRow    = 2'd1;
  localparam cfg_idx_t CfgFirst  = 2'd2;
  localparam cfg_idx_t CfgSecond = 2'd3;

  // Result tdata bit positions
  localparam int OutData   = 0;
  localparam int OutLatch  = 1;
  localparam int OutEnN    = 2;
  localparam int OutClk    = 3;
  localparam int OutBusy   = 4;
  localparam int OutEdge   = 5;

endpackage

/* design/led_panel_driver_init_sequencer.sv */
// Top level: LED panel scan-driver configuration sequencer.
// Each input transaction's result is computed combinationally and captured in the output register on acceptance.
// Throughput: one tick per cycle unless the output stalls; the next state and result come from one pass of
//   logic behind the result register, which frees whenever its transaction completes.
// Reset: synchronous; sequencer returns to idle, latch, enable and edge flags clear,
//   registers take their defaults (FM kind, 64-pixel rows, words 2016 and 64).
`timescale 1ns / 1ps

module led_panel_driver_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] data_level [1] latch_level [2] enable_n
                                      // [3] clock_pulse [4] busy_res [5] positive_edge
  output logic        m_axis_tlast,   // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhFmW1    = 4'd1;
  localparam logic [3:0] PhFmW2    = 4'd2;
  localparam logic [3:0] PhFmBlank = 4'd3;
  localparam logic [3:0] PhFmLatch = 4'd4;
  localparam logic [3:0] PhFmFinal = 4'd5;
  localparam logic [3:0] PhDpBlk1  = 4'd6;
  localparam logic [3:0] PhDpW1    = 4'd7;
  localparam logic [3:0] PhDpW2    = 4'd8;
  localparam logic [3:0] PhDpExtra = 4'd9;
  localparam logic [3:0] PhDpBlk2  = 4'd10;
  localparam logic [3:0] PhDpFinal = 4'd11;

  localparam int          CW      = lpdi_pkg::ColWidth;
  localparam logic [CW:0] MaxRowW = (CW+1)'(lpdi_pkg::MaxRow);
  localparam logic [CW:0] MinRowW = (CW+1)'(lpdi_pkg::MinRow);

  lpdi_pkg::kind_t  driver_kind;
  lpdi_pkg::col_t   row_pixels;
  lpdi_pkg::word_t  first_word;
  lpdi_pkg::word_t  second_word;

  logic [3:0]       phase, phase_next;
  lpdi_pkg::col_t   column, column_next;
  logic             latch_reg, latch_reg_next;
  logic             enable_n_reg, enable_n_reg_next;
  logic             edge_flag, edge_flag_next;

  logic             in_fire, cfg_fire, start;
  logic [3:0]       cur;
  lpdi_pkg::col_t   col, col_inc, p, pm1;
  logic [CW:0]      rp_w, col_w;
  logic             row_end;
  logic             data_o, clk_o, busy_o, done_o;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign start         = s_axis_tdata[0];

  // Clamp row length
  always_comb begin
    rp_w = {1'b0, row_pixels};
    if (rp_w < MinRowW) begin
      p = CW'(MinRowW);
    end else if (rp_w > MaxRowW) begin
      p = CW'(MaxRowW);
    end else begin
      p = row_pixels;
    end
  end

  assign pm1 = p - CW'(1);

  always_comb begin
    cur               = phase;
    col               = column;
    phase_next        = phase;
    column_next       = column;
    latch_reg_next    = latch_reg;
    enable_n_reg_next = enable_n_reg;
    edge_flag_next    = edge_flag;
    data_o            = 1'b0;
    clk_o             = 1'b0;
    busy_o            = 1'b0;
    done_o            = 1'b0;

    if (phase == PhIdle && start) begin
      if (driver_kind == lpdi_pkg::KindFm) begin
        cur               = PhFmW1;
        col               = '0;
        column_next       = '0;
        enable_n_reg_next = 1'b1;
      end else if (driver_kind == lpdi_pkg::KindDp) begin
        cur               = PhDpBlk1;
        col               = '0;
        column_next       = '0;
        enable_n_reg_next = 1'b1;
        edge_flag_next    = 1'b1;
      end else begin
        if (driver_kind == lpdi_pkg::KindMbi) begin
          edge_flag_next = 1'b1;
        end
        latch_reg_next = 1'b0;
        busy_o         = 1'b1;
        done_o         = 1'b1;
      end
    end

    col_inc = col + CW'(1);
    col_w   = {1'b0, col};
    row_end = col_inc >= p;

    if (cur != PhIdle) begin
      busy_o     = 1'b1;
      clk_o      = 1'b1;
      phase_next = cur;
      unique case (cur) inside
        PhFmW1, PhDpW1: begin
          data_o         = first_word[4'd15 - col[3:0]];
          latch_reg_next = (col_w + (CW+1)'(11)) >= {1'b0, p};
          column_next    = row_end ? '0 : col_inc;
          if (row_end) begin
            phase_next = (cur == PhFmW1) ? PhFmW2 : PhDpW2;
          end
        end
        PhFmW2, PhDpW2: begin
          data_o         = second_word[4'd15 - col[3:0]];
          latch_reg_next = (col_w + (CW+1)'(12)) >= {1'b0, p};
          column_next    = row_end ? '0 : col_inc;
          if (row_end) begin
            phase_next = (cur == PhFmW2) ? PhFmBlank : PhDpExtra;
          end
        end
        PhFmBlank: begin
          latch_reg_next = 1'b0;
          column_next    = row_end ? '0 : col_inc;
          if (row_end) begin
            phase_next = PhFmLatch;
          end
        end
        PhFmLatch: begin
          latch_reg_next = 1'b1;
          phase_next     = PhFmFinal;
        end
        PhDpBlk1, PhDpBlk2: begin
          latch_reg_next = (col_w + (CW+1)'(3)) >= {1'b0, p};
          column_next    = row_end ? '0 : col_inc;
          if (row_end) begin
            phase_next = (cur == PhDpBlk1) ? PhDpW1 : PhDpFinal;
          end
        end
        PhDpExtra: begin
          data_o         = second_word[4'd15 - pm1[3:0]];
          latch_reg_next = 1'b0;
          phase_next     = PhDpBlk2;
        end
        default: begin
          latch_reg_next    = 1'b0;
          enable_n_reg_next = 1'b0;
          done_o            = 1'b1;
          phase_next        = PhIdle;
          column_next       = '0;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      driver_kind <= lpdi_pkg::KindFm;
      row_pixels  <= lpdi_pkg::col_t'(64);
      first_word  <= lpdi_pkg::word_t'(2016);
      second_word <= lpdi_pkg::word_t'(64);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        lpdi_pkg::CfgKind:   driver_kind <= cfg_data[1:0];
        lpdi_pkg::CfgRow:    row_pixels  <= cfg_data[CW-1:0];
        lpdi_pkg::CfgFirst:  first_word  <= cfg_data;
        lpdi_pkg::CfgSecond: second_word <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhIdle;
      column        <= '0;
      latch_reg     <= 1'b0;
      enable_n_reg  <= 1'b0;
      edge_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      column        <= column_next;
      latch_reg     <= latch_reg_next;
      enable_n_reg  <= enable_n_reg_next;
      edge_flag     <= edge_flag_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {2'b00, edge_flag_next, busy_o, clk_o, enable_n_reg_next,
                       latch_reg_next, data_o};
      m_axis_tlast <= done_o;
    end
  end

endmodule

/* design/lpdi_checker.sv */
// Port-level checker for the LED panel driver init sequencer, with its bind.
`timescale 1ns / 1ps

module lpdi_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic seen_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_edge <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[lpdi_pkg::OutEdge]) begin
      seen_edge <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tlast || m_axis_tdata[lpdi_pkg::OutClk]) |->
      m_axis_tdata[lpdi_pkg::OutBusy])
    else $error("done or shift clock outside a sequence");

  a_clk_disabled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[lpdi_pkg::OutClk] && !m_axis_tlast |->
      m_axis_tdata[lpdi_pkg::OutEnN])
    else $error("output enabled while shifting configuration");

  a_edge_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seen_edge |-> m_axis_tdata[lpdi_pkg::OutEdge])
    else $error("positive edge flag cleared");

endmodule

bind led_panel_driver_init_sequencer lpdi_checker u_lpdi_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
